// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, masked during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/psm_pkg.sv
// ---------------------------------------------------------------------------
// psm_pkg
// Types and constants shared by the sample player and mixer.
// ---------------------------------------------------------------------------
package psm_pkg;

  localparam int VOICES_DEF       = 8;
  localparam int SAMPLE_WORDS_DEF = 65536;
  localparam int SAMPLE_W         = 16;
  localparam int TABLE_REGS       = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int DAC_MID          = 2048;
  localparam int DAC_MAX          = 4095;
  localparam int CODE_MAX         = 7;
  localparam int MIX_SHIFT        = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_TRIGGER = 2'd1,
    FUNC_TICK    = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_STARTED = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_BUSY    = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_WALK,
    ST_DIV,
    ST_RESP
  } state_t;

  typedef struct packed {
    func_t                      func;
    logic [15:0]                load_address;
    logic signed [SAMPLE_W-1:0] load_sample;
    logic [7:0]                 drum_code;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dac_value;
    status_t     status;
    logic [2:0]  started_voice;
    logic [3:0]  voices_mixed;
  } out_item_t;

  // One entry of the voice memory
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] pos;
  } voice_t;

endpackage

// File: src/psm_div.sv
// ---------------------------------------------------------------------------
// psm_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
module psm_div #(
  parameter int DIVISOR_W  = $clog2(psm_pkg::VOICES_DEF + 1),
  parameter int DIVIDEND_W = psm_pkg::SAMPLE_W + DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  den_r, den_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;

  assign rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIVIDEND_W);
      neg_nxt  = dividend[DIVIDEND_W-1];
      quo_nxt  = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits carry it
      rem_nxt  = fits ? DIVISOR_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DIVIDEND_W'(1)) : quo_r;

endmodule

// File: src/polyphonic_sample_mixer.sv
// ---------------------------------------------------------------------------
// polyphonic_sample_mixer
// Multi-voice one-shot sample player: load words into the sample store,
// trigger voices from the drum table, mix one output sample per tick.
// ---------------------------------------------------------------------------
//
//   port group | direction | handshake          | carries
//   -----------+-----------+--------------------+---------------------------
//   in_        | input     | in_valid/in_ready  | in_item_t: load/trigger/tick
//   out_       | output    | out_valid/out_ready| out_item_t: dac, status
//   cfg_       | input     | cfg_we only        | drum table register write
//
// A load goes straight to the response state, a trigger passes the trigger
// state first. A tick walks the voice memory (one voice read a cycle) and,
// when any voice was mixed, runs the bit-serial divider that averages the
// sum.
// Reset (synchronous): clears voice active bits, drum table, FSM and output
// valid. The sample store is not initialised and needs no clearing pass.
// A finished item waits in the output register; the next item is accepted
// meanwhile, and its result is held until the output register is free.
//
`include "assert_macros.svh"

module polyphonic_sample_mixer #(
  parameter int VOICES       = psm_pkg::VOICES_DEF,
  parameter int SAMPLE_WORDS = psm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  psm_pkg::in_item_t               in_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output psm_pkg::out_item_t              out_data,
  // drum table writes
  input  logic                            cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int SUM_W  = psm_pkg::SAMPLE_W + CNT_W;
  localparam int AW     = $clog2(SAMPLE_WORDS);

  // ------------------------------------------------------------------
  // Storage
  // ------------------------------------------------------------------
  logic [psm_pkg::SAMPLE_W-1:0]   smem [SAMPLE_WORDS];
  logic [psm_pkg::SAMPLE_W-1:0]   smem_rdata_r;
  psm_pkg::voice_t                vmem [VOICES];
  psm_pkg::voice_t                vmem_rdata_r;
  logic [psm_pkg::CFG_DATA_W-1:0] drum_tbl_r [psm_pkg::TABLE_REGS];

  // ------------------------------------------------------------------
  // Control and datapath registers
  // ------------------------------------------------------------------
  psm_pkg::state_t    state_r, state_nxt;
  logic [VOICES-1:0]  active_r, active_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_nxt;
  logic               s1_vld_r, s1_vld_nxt;
  logic [VIDX_W-1:0]  s1_idx_r, s1_idx_nxt;
  logic               s2_vld_r, s2_vld_nxt;
  logic               s2_inrng_r, s2_inrng_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         code_r, code_nxt;
  psm_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  psm_pkg::out_item_t out_data_r, out_data_nxt;

  // memory port controls
  logic               vmem_we, vmem_re;
  logic [VIDX_W-1:0]  vmem_waddr, vmem_raddr;
  psm_pkg::voice_t    vmem_wdata;
  logic               smem_re;
  logic [AW-1:0]      smem_raddr;

  // misc combinational
  logic                           in_fire, out_free, load_inrng, walk_end;
  logic                           free_found;
  logic [VIDX_W-1:0]              free_idx;
  logic [psm_pkg::CFG_DATA_W-1:0] tbl_word;
  logic [15:0]                    samp_addr;
  logic                           samp_inrng;
  logic [SUM_W-1:0]               samp_ext;
  logic                           div_start, div_done;
  logic [SUM_W-1:0]               div_quo, mix_q;
  logic [SUM_W:0]                 mix_v;
  logic [11:0]                    mix_dac;

  assign in_ready   = (state_r == psm_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign load_inrng = ({1'b0, in_data.load_address} < 17'(SAMPLE_WORDS));

  // walk is finished once every voice has been issued and both stages drained
  assign walk_end = (iss_cnt_r == CNT_W'(VOICES)) && !s1_vld_r && !s2_vld_r;

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  assign tbl_word   = drum_tbl_r[code_r[psm_pkg::CFG_IDX_W-1:0]];
  assign samp_addr  = vmem_rdata_r.base + vmem_rdata_r.pos;   // wraps at 16 bits
  assign samp_inrng = ({1'b0, samp_addr} < 17'(SAMPLE_WORDS));
  assign samp_ext   = {{(SUM_W - psm_pkg::SAMPLE_W){smem_rdata_r[psm_pkg::SAMPLE_W-1]}},
                       smem_rdata_r};

  // average -> floor shift by 4 -> offset -> clamp
  assign mix_q = {{psm_pkg::MIX_SHIFT{div_quo[SUM_W-1]}}, div_quo[SUM_W-1:psm_pkg::MIX_SHIFT]};
  assign mix_v = {mix_q[SUM_W-1], mix_q} + (SUM_W + 1)'(psm_pkg::DAC_MID);

  always_comb begin
    if (mix_v[SUM_W]) begin
      mix_dac = '0;
    end else if (mix_v[SUM_W-1:0] > SUM_W'(psm_pkg::DAC_MAX)) begin
      mix_dac = 12'(psm_pkg::DAC_MAX);
    end else begin
      mix_dac = mix_v[11:0];
    end
  end

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psm_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.func)
            psm_pkg::FUNC_TRIGGER: state_nxt = psm_pkg::ST_TRIG;
            psm_pkg::FUNC_TICK:    state_nxt = psm_pkg::ST_WALK;
            default:               state_nxt = psm_pkg::ST_RESP;  // load, unused code
          endcase
        end
      end
      psm_pkg::ST_TRIG: state_nxt = psm_pkg::ST_RESP;
      psm_pkg::ST_WALK: begin
        if (walk_end) begin
          state_nxt = (cnt_r == '0) ? psm_pkg::ST_RESP : psm_pkg::ST_DIV;
        end
      end
      psm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = psm_pkg::ST_RESP;
        end
      end
      psm_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = psm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psm_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath and memory controls per state
  // ------------------------------------------------------------------
  always_comb begin
    active_nxt   = active_r;
    iss_nxt      = iss_cnt_r;
    s1_vld_nxt   = 1'b0;
    s1_idx_nxt   = s1_idx_r;
    s2_vld_nxt   = 1'b0;
    s2_inrng_nxt = s2_inrng_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    code_nxt     = code_r;
    res_nxt      = res_r;
    vmem_we      = 1'b0;
    vmem_waddr   = s1_idx_r;
    vmem_wdata   = vmem_rdata_r;
    vmem_re      = 1'b0;
    vmem_raddr   = iss_cnt_r[VIDX_W-1:0];
    smem_re      = 1'b0;
    smem_raddr   = samp_addr[AW-1:0];
    div_start    = 1'b0;

    case (state_r)
      psm_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          code_nxt  = in_data.drum_code;
          iss_nxt   = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
        end
      end

      psm_pkg::ST_TRIG: begin
        // invalid code, then all busy, then empty sample
        if (code_r > 8'(psm_pkg::CODE_MAX)) begin
          res_nxt.status = psm_pkg::STAT_INVALID;
        end else if (!free_found) begin
          res_nxt.status = psm_pkg::STAT_BUSY;
        end else if (tbl_word[15:0] == '0) begin
          res_nxt.status = psm_pkg::STAT_EMPTY;
        end else begin
          vmem_we                = 1'b1;
          vmem_waddr             = free_idx;
          vmem_wdata.base        = tbl_word[31:16];
          vmem_wdata.len         = tbl_word[15:0];
          vmem_wdata.pos         = '0;
          active_nxt[free_idx]   = 1'b1;
          res_nxt.status         = psm_pkg::STAT_STARTED;
          res_nxt.started_voice  = 3'(free_idx);
        end
      end

      psm_pkg::ST_WALK: begin
        // issue: one voice entry read per cycle
        if (iss_cnt_r < CNT_W'(VOICES)) begin
          vmem_re    = 1'b1;
          s1_vld_nxt = 1'b1;
          s1_idx_nxt = iss_cnt_r[VIDX_W-1:0];
          iss_nxt    = iss_cnt_r + CNT_W'(1);
        end
        // stage 1: voice entry back; advance or free, fetch the sample
        if (s1_vld_r && active_r[s1_idx_r]) begin
          if (vmem_rdata_r.pos < vmem_rdata_r.len) begin
            vmem_we        = 1'b1;
            vmem_wdata.pos = vmem_rdata_r.pos + 16'd1;
            smem_re        = samp_inrng;
            s2_vld_nxt     = 1'b1;
            s2_inrng_nxt   = samp_inrng;
          end else begin
            active_nxt[s1_idx_r] = 1'b0;
          end
        end
        // stage 2: accumulate; out-of-store reads count as zero
        if (s2_vld_r) begin
          sum_nxt = sum_r + (s2_inrng_r ? samp_ext : '0);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (walk_end) begin
          res_nxt.voices_mixed = 4'(cnt_r);
          if (cnt_r == '0) begin
            res_nxt.dac_value = 12'(psm_pkg::DAC_MID);
          end else begin
            div_start = 1'b1;
          end
        end
      end

      psm_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt.dac_value = mix_dac;
        end
      end

      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if ((state_r == psm_pkg::ST_RESP) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------
  // Divider for the voice average
  // ------------------------------------------------------------------
  psm_div #(
    .DIVISOR_W  (CNT_W),
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psm_pkg::ST_IDLE;
      active_r    <= '0;
      iss_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      iss_cnt_r   <= iss_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= s1_idx_nxt;
    s2_inrng_r <= s2_inrng_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    code_r     <= code_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // drum table registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psm_pkg::TABLE_REGS; i++) begin
        drum_tbl_r[i] <= '0;
      end
    end else if (cfg_we) begin
      drum_tbl_r[cfg_index] <= cfg_data;
    end
  end

  // voice memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_waddr] <= vmem_wdata;
    end
    if (vmem_re) begin
      vmem_rdata_r <= vmem[vmem_raddr];
    end
  end

  // sample store: written by load items, read during the walk
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.func == psm_pkg::FUNC_LOAD) && load_inrng) begin
      smem[in_data.load_address[AW-1:0]] <= in_data.load_sample;
    end
    if (smem_re) begin
      smem_rdata_r <= smem[smem_raddr];
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `ASSERT_ALWAYS(a_pipe_in_walk, (s1_vld_r || s2_vld_r) |-> (state_r == psm_pkg::ST_WALK), "walk stage busy outside tick")
  `ASSERT_ALWAYS(a_div_in_div, div_done |-> (state_r == psm_pkg::ST_DIV), "divider finished outside divide state")
  `ASSERT_ALWAYS(a_start_sets_active, ((state_r == psm_pkg::ST_TRIG) && (res_nxt.status == psm_pkg::STAT_STARTED)) |=> active_r[$past(free_idx)], "started voice not marked active")
  `ASSERT_NEVER(a_vmem_no_overlap, vmem_we && vmem_re && (vmem_waddr == vmem_raddr), "voice entry read and written in one cycle")

endmodule

// File: tb/tb_polyphonic_sample_mixer.sv
// ---------------------------------------------------------------------------
// tb_polyphonic_sample_mixer
// Self-checking bench for the eight-voice sample player and mixer. A small
// scoreboard class keeps its own voices, drum table and sample store, works
// out the result of every accepted item and checks the block's results in
// order. Directed items cover the corners, then random phases with different
// drum tables run load/trigger/tick traffic, stalled in all but the last.
// ---------------------------------------------------------------------------
module tb_polyphonic_sample_mixer;
  import psm_pkg::*;

  // func value the block leaves unused; such items must come back all zero
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  // lengths above this count as long voices that outlive the run
  localparam int         LONG_LEN       = 1024;
  // at most this many long voices are let loose, so the rest keep cycling
  localparam int         LONG_CAP       = 3;
  // quiet cycles after the last result before a table write or the end
  localparam int         SETTLE_CYCLES  = 48;
  // cycles with no item moving on either side before the run is abandoned
  localparam int         WATCHDOG_LIMIT = 4000;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of voices, table and store; expected results queue
  // -------------------------------------------------------------------------
  class mixer_checker;
    logic [CFG_DATA_W-1:0] drum_regs   [TABLE_REGS];
    bit                    voice_on    [VOICES_DEF];
    logic [15:0]           voice_start [VOICES_DEF];
    logic [15:0]           voice_len   [VOICES_DEF];
    logic [15:0]           voice_pos   [VOICES_DEF];
    // only written entries exist here
    logic [SAMPLE_W-1:0]   sample_words [int];
    out_item_t             pending_results [$];
    int                    errors;

    function new();
      foreach (drum_regs[i]) drum_regs[i] = '0;
      foreach (voice_on[i]) begin
        voice_on[i]    = 1'b0;
        voice_start[i] = '0;
        voice_len[i]   = '0;
        voice_pos[i]   = '0;
      end
      errors = 0;
    endfunction

    // advance the voices by one item and return what the block should say
    function out_item_t play_item(in_item_t it);
      out_item_t             r;
      logic [CFG_DATA_W-1:0] entry;
      logic [15:0]           addr;
      logic [SAMPLE_W-1:0]   word;
      int                    slot;
      int                    sum;
      int                    count;
      int                    avg;
      int                    level;
      r = '0;
      case (it.func)
        FUNC_LOAD: begin
          sample_words[it.load_address] = it.load_sample;
        end
        FUNC_TRIGGER: begin
          if (it.drum_code > CODE_MAX) begin
            r.status = STAT_INVALID;
          end else begin
            entry = drum_regs[it.drum_code[2:0]];
            slot  = -1;
            for (int i = VOICES_DEF - 1; i >= 0; i--) begin
              if (!voice_on[i]) slot = i;
            end
            // busy is reported ahead of an empty sample
            if (slot < 0) begin
              r.status = STAT_BUSY;
            end else if (entry[15:0] == '0) begin
              r.status = STAT_EMPTY;
            end else begin
              voice_on[slot]    = 1'b1;
              voice_start[slot] = entry[31:16];
              voice_len[slot]   = entry[15:0];
              voice_pos[slot]   = '0;
              r.status          = STAT_STARTED;
              r.started_voice   = 3'(slot);
            end
          end
        end
        FUNC_TICK: begin
          sum   = 0;
          count = 0;
          for (int i = 0; i < VOICES_DEF; i++) begin
            if (voice_on[i]) begin
              if (voice_pos[i] < voice_len[i]) begin
                addr         = voice_start[i] + voice_pos[i];  // wraps at 16 bits
                word         = sample_words[addr];
                sum          = sum + int'($signed(word));
                count++;
                voice_pos[i] = voice_pos[i] + 16'd1;
              end else begin
                // end of sample: freed on this tick, adds nothing
                voice_on[i]    = 1'b0;
                voice_start[i] = '0;
                voice_len[i]   = '0;
                voice_pos[i]   = '0;
              end
            end
          end
          if (count == 0) begin
            level = DAC_MID;
          end else begin
            avg   = sum / count;               // truncates toward zero
            level = DAC_MID + (avg >>> MIX_SHIFT);
            if (level < 0) level = 0;
            if (level > DAC_MAX) level = DAC_MAX;
          end
          r.status       = STAT_DONE;
          r.dac_value    = 12'(level);
          r.voices_mixed = 4'(count);
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_results.push_back(play_item(it));
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected none, got dac %0d status %0d voice %0d mixed %0d",
                 $time, got.dac_value, got.status, got.started_voice, got.voices_mixed);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("dac_value", want.dac_value, got.dac_value);
        compare_field("status", want.status, got.status);
        compare_field("started_voice", want.started_voice, got.started_voice);
        compare_field("voices_mixed", want.voices_mixed, got.voices_mixed);
      end
    endfunction

    // next store address a tick would read that was never loaded, if any
    function bit unwritten_read(output logic [15:0] addr);
      addr = '0;
      for (int i = 0; i < VOICES_DEF; i++) begin
        if (voice_on[i] && voice_pos[i] < voice_len[i]) begin
          addr = voice_start[i] + voice_pos[i];
          if (!sample_words.exists(addr)) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int long_voices();
      int n;
      n = 0;
      foreach (voice_on[i]) begin
        if (voice_on[i] && voice_len[i] > LONG_LEN) n++;
      end
      return n;
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, DUT and bench state
  // -------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mixer_checker          sb = new();
  bit                    idle_on = 1'b1;   // random stalls on both sides
  logic [CFG_DATA_W-1:0] table_words [TABLE_REGS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  polyphonic_sample_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // every field random, so the ones an item ignores toggle too
  function automatic in_item_t random_item(func_t f);
    in_item_t it;
    it.func         = f;
    it.load_address = 16'($urandom);
    it.load_sample  = 16'($urandom);
    it.drum_code    = 8'($urandom);
    return it;
  endfunction

  // full-scale words often, so the clamp edges come up
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short samples; some empty, some at the top of the store, a few huge
  function automatic logic [CFG_DATA_W-1:0] random_drum_entry();
    logic [15:0] base;
    logic [15:0] len;
    int          sel_b;
    int          sel_l;
    sel_b = $urandom_range(0, 9);
    sel_l = $urandom_range(0, 19);
    if (sel_b == 0) base = '0;
    else if (sel_b == 1) base = 16'(16'hFFF0 + $urandom_range(0, 15));
    else base = 16'($urandom);
    if (sel_l < 2) len = '0;
    else if (sel_l == 2) len = 16'hFFFF;
    else len = 16'($urandom_range(1, 24));
    return {base, len};
  endfunction

  // hold valid until accepted; an idle burst may come first
  task automatic send(in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic load(logic [15:0] addr, logic [15:0] word);
    in_item_t it;
    it              = random_item(FUNC_LOAD);
    it.load_address = addr;
    it.load_sample  = word;
    send(it);
  endtask

  task automatic trigger(logic [7:0] code);
    in_item_t it;
    it           = random_item(FUNC_TRIGGER);
    it.drum_code = code;
    send(it);
  endtask

  // load whatever the coming tick would read unwritten, then tick
  task automatic tick();
    logic [15:0] addr;
    while (sb.unwritten_read(addr)) load(addr, random_word());
    send(random_item(FUNC_TICK));
  endtask

  task automatic noise();
    send(random_item(func_t'(FUNC_UNUSED)));
  endtask

  // drop valid and wait for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all eight table registers back to back
  task automatic load_drum_table();
    for (int i = 0; i < TABLE_REGS; i++) begin
      cfg_we       <= 1'b1;
      cfg_index    <= CFG_IDX_W'(i);
      cfg_data     <= table_words[i];
      sb.drum_regs[i] = table_words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Directed corners
  // -------------------------------------------------------------------------
  task automatic run_directed();
    // table still all zero: every code empty, a tick with nothing playing
    trigger(8'd0);
    tick();
    noise();
    trigger(8'd255);
    settle();

    table_words[0] = {16'h0000, 16'd4};
    table_words[1] = {16'hFFFE, 16'd4};      // wraps past the top of the store
    table_words[2] = {16'h1234, 16'd0};      // empty
    table_words[3] = {16'h0100, 16'd1};
    table_words[4] = {16'h0200, 16'hFFFF};   // longest sample
    table_words[5] = {16'hFFFF, 16'd2};
    table_words[6] = {16'h0010, 16'd8};
    table_words[7] = {16'h0300, 16'd3};
    load_drum_table();

    for (int a = 0; a < 4; a++) load(16'(a), 16'h7FFF);
    load(16'hFFFE, 16'h8000);
    load(16'hFFFF, 16'h8000);

    trigger(8'd0);
    tick();                   // lone full-scale positive voice: top of the DAC range
    trigger(8'd1);
    tick();                   // +max and -max: sum -1 truncates to zero
    tick();
    tick();                   // voice 0 ends here
    tick();                   // voice 0 freed, adds nothing
    for (int c = 3; c <= 7; c++) trigger(8'(c));
    trigger(8'd7);
    trigger(8'd7);            // all eight voices now playing
    trigger(8'd7);            // all busy
    trigger(8'd9);            // invalid wins over busy
    trigger(8'd2);            // busy wins over empty
    tick();
    tick();
    trigger(8'd2);            // a voice is free again: empty sample
  endtask

  // -------------------------------------------------------------------------
  // Random traffic; mostly well-formed play with random content
  // -------------------------------------------------------------------------
  task automatic random_run(int count);
    int          pick;
    logic [7:0]  code;
    logic [2:0]  c;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        code = 8'($urandom_range(0, CODE_MAX));
        if (sb.drum_regs[code[2:0]][15:0] > LONG_LEN && sb.long_voices() >= LONG_CAP) begin
          tick();
        end else begin
          trigger(code);
        end
      end else if (pick < 34) begin
        load(16'($urandom), random_word());
      end else if (pick < 45) begin
        // rewrite words inside a sample, possibly one that is playing
        c = 3'($urandom_range(0, TABLE_REGS - 1));
        load(sb.drum_regs[c][31:16] + 16'($urandom_range(0, 31)), random_word());
      end else if (pick < 52) begin
        trigger(8'($urandom_range(CODE_MAX + 1, 255)));
      end else if (pick < 55) begin
        noise();
      end else begin
        tick();
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random back-pressure bursts
  // -------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_data);
  end

  // watchdog: too long with no item moving either way
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int phase_items;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // phase 1: every register all ones; phase 2: all zero (every code empty);
    // the rest random; the last phase runs with no stalls at all
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      for (int i = 0; i < TABLE_REGS; i++) begin
        if (ph == 1) table_words[i] = '1;
        else if (ph == 2) table_words[i] = '0;
        else table_words[i] = random_drum_entry();
      end
      load_drum_table();
      idle_on     = (ph != 5);
      phase_items = (ph == 1) ? 120 : (ph == 2) ? 80 : 300;
      random_run(phase_items);
    end

    settle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: polyphonic_sample_mixer.f
+incdir+src
src/psm_pkg.sv
src/psm_div.sv
src/polyphonic_sample_mixer.sv
tb/tb_polyphonic_sample_mixer.sv
